@@ rtl/dtes_pkg.sv @@
// Shared types, constants and helpers for the display/timer event scheduler.
// No dependencies; imported by every module of the block.
package dtes_pkg;

  localparam int unsigned MaxTimers    = 4;   // timer slots on the ports
  localparam int unsigned NumTimers    = 4;   // timers that run (1..MaxTimers)
  localparam int unsigned CntW         = 42;  // timer count, signed
  localparam int unsigned FloorExp     = 40;  // timer count floor is -2^FloorExp
  localparam int unsigned DispW        = 13;  // display countdown, signed
  localparam int unsigned ElW          = 12;
  localparam int unsigned CfgW         = 26;

  localparam int DrawCycles   = 960;
  localparam int HblankCycles = 272;
  localparam int VblankLine   = 160;
  localparam int FrameLines   = 228;
  localparam int DispFloor    = -4096;

  typedef logic signed [CntW-1:0] tcount_t;

  localparam tcount_t CountFloor = {{(CntW-FloorExp){1'b1}}, {FloorExp{1'b0}}};

  typedef enum logic [2:0] {
    RegLineCmp = 3'd0,
    RegIrqEn   = 3'd1,
    RegTimer0  = 3'd2,
    RegTimer1  = 3'd3,
    RegTimer2  = 3'd4,
    RegTimer3  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    TmOff      = 2'd0,
    TmPrescale = 2'd1,
    TmCascade  = 2'd2,
    TmOffAlt   = 2'd3
  } tmode_e;

  typedef struct packed {
    logic [1:0]  sound;
    logic        irq_en;
    tmode_e      mode;
    logic [3:0]  shift;
    logic [16:0] period;
  } setup_t;

  typedef struct packed {
    logic            en;
    logic [2:0]      idx;
    logic [CfgW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0]              irq;
    logic [7:0]              line;
    logic [2:0]              flags;
    logic                    hpulse;
    logic                    vpulse;
    logic                    fpulse;
    logic signed [DispW-1:0] countdown;
  } disp_out_t;

  typedef struct packed {
    logic [MaxTimers-1:0]        ovf;
    logic [MaxTimers-1:0]        irq;
    logic [MaxTimers-1:0]        prescale;
    tcount_t [MaxTimers-1:0]     count;
    logic [MaxTimers-1:0][15:0]  value;
  } timer_out_t;

  // Period field, zero or out of range reads as 65536
  function automatic logic [16:0] setup_period(setup_t s);
    logic [16:0] p;
    p = s.period;
    if (p == '0 || p > 17'h10000) p = 17'h10000;
    return p;
  endfunction

  function automatic tcount_t reload_amount(setup_t s);
    tcount_t p;
    p = tcount_t'({{(CntW-17){1'b0}}, setup_period(s)});
    if (s.mode == TmCascade) return p;
    return p << s.shift;
  endfunction

  function automatic tcount_t sat_sub(tcount_t c, tcount_t d);
    tcount_t diff;
    diff = c - d;
    if (diff < CountFloor) diff = CountFloor;
    return diff;
  endfunction

  function automatic logic [15:0] neg16(tcount_t c);
    tcount_t n;
    n = -c;
    return n[15:0];
  endfunction

endpackage

@@ rtl/dtes_display.sv @@
// Line timing: countdown, line counter, blank/match flags and display irqs.
// Depends on dtes_pkg.
module dtes_display import dtes_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_wr_t         cfg_i,
  input  logic            step_i,
  input  logic [ElW-1:0]  el_i,
  output disp_out_t       nxt_o
);

  logic signed [DispW-1:0] cd_q;
  logic [7:0]              line_q;
  logic [2:0]              flags_q;
  logic [7:0]              cmp_q;
  logic [2:0]              en_q;

  logic signed [DispW:0]   cd;
  logic [7:0]              line_n;

  always_comb begin
    nxt_o        = '0;
    nxt_o.line   = line_q;
    nxt_o.flags  = flags_q;
    line_n       = line_q + 8'd1;
    cd           = {cd_q[DispW-1], cd_q} - $signed({{(DispW+1-ElW){1'b0}}, el_i});
    if (cd < DispFloor) cd = (DispW+1)'(DispFloor);
    if (cd <= 0) begin
      if (!flags_q[1]) begin
        // draw -> hblank
        cd             = cd + (DispW+1)'(HblankCycles);
        nxt_o.flags[1] = 1'b1;
        nxt_o.hpulse   = ~flags_q[0];
        nxt_o.irq[1]   = en_q[1];
      end else begin
        // hblank -> next line
        cd             = cd + (DispW+1)'(DrawCycles);
        nxt_o.flags[1] = 1'b0;
        nxt_o.line     = line_n;
        if (line_n == 8'(VblankLine)) begin
          nxt_o.flags[0] = 1'b1;
          nxt_o.vpulse   = 1'b1;
          nxt_o.irq[0]   = en_q[0];
        end else if (line_n >= 8'(FrameLines)) begin
          nxt_o.flags[0] = 1'b0;
          nxt_o.fpulse   = 1'b1;
          nxt_o.line     = '0;
        end
        if (nxt_o.line == cmp_q) begin
          nxt_o.flags[2] = 1'b1;
          nxt_o.irq[2]   = en_q[2];
        end else begin
          nxt_o.flags[2] = 1'b0;
        end
      end
    end
    nxt_o.countdown = cd[DispW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q    <= DispW'(DrawCycles);
      line_q  <= '0;
      flags_q <= '0;
      cmp_q   <= '0;
      en_q    <= '0;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        RegLineCmp: cmp_q <= cfg_i.data[7:0];
        RegIrqEn:   en_q  <= cfg_i.data[2:0];
        default:    ;
      endcase
    end else if (step_i) begin
      cd_q    <= nxt_o.countdown;
      line_q  <= nxt_o.line;
      flags_q <= nxt_o.flags;
    end
  end

endmodule

@@ rtl/dtes_timers.sv @@
// Four cascadable timers: setups, counts, read values and overflow chain.
// Depends on dtes_pkg.
module dtes_timers import dtes_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_wr_t         cfg_i,
  input  logic            step_i,
  input  logic [ElW-1:0]  el_i,
  output timer_out_t      nxt_o
);

  setup_t      setup_q [MaxTimers];
  tcount_t     cnt_q   [MaxTimers];
  logic [15:0] val_q   [MaxTimers];

  tcount_t     el_ext;
  tcount_t     c;
  tmode_e      mode;
  logic        carry;

  assign el_ext = tcount_t'({{(CntW-ElW){1'b0}}, el_i});

  // Timers run in order; an overflow decrements the next one if it cascades
  always_comb begin
    nxt_o = '0;
    carry = 1'b0;
    c     = '0;
    mode  = TmOff;
    for (int n = 0; n < MaxTimers; n++) begin
      c                 = cnt_q[n];
      nxt_o.value[n]    = val_q[n];
      mode              = setup_q[n].mode;
      if (n < NumTimers) begin
        if (carry && mode == TmCascade) begin
          c              = sat_sub(c, tcount_t'(1));
          nxt_o.value[n] = neg16(c);
        end
        carry = 1'b0;
        if (mode == TmPrescale) begin
          c              = sat_sub(c, el_ext);
          nxt_o.value[n] = neg16(c >>> setup_q[n].shift);
        end
        if ((mode == TmPrescale || mode == TmCascade) && c <= 0) begin
          nxt_o.ovf[n] = 1'b1;
          nxt_o.irq[n] = setup_q[n].irq_en;
          carry        = 1'b1;
          c            = c + reload_amount(setup_q[n]);
        end
        nxt_o.prescale[n] = (mode == TmPrescale);
      end else begin
        nxt_o.value[n] = '0;
      end
      nxt_o.count[n] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < MaxTimers; n++) begin
        setup_q[n] <= (n == 0) ? setup_t'(CfgW'(32'h3010000)) : setup_t'(CfgW'(32'h10000));
        cnt_q[n]   <= tcount_t'(65536);
        val_q[n]   <= '0;
      end
    end else if (cfg_i.en) begin
      for (int n = 0; n < MaxTimers; n++) begin
        if (cfg_i.idx == 3'(int'(RegTimer0) + n)) begin
          setup_q[n] <= (n < 2) ? setup_t'(cfg_i.data)
                                : setup_t'({2'b00, cfg_i.data[CfgW-3:0]});
          if (n < NumTimers) begin
            cnt_q[n] <= reload_amount((n < 2) ? setup_t'(cfg_i.data)
                                              : setup_t'({2'b00, cfg_i.data[CfgW-3:0]}));
            val_q[n] <= 16'(17'h10000 - setup_period(setup_t'(cfg_i.data)));
          end
        end
      end
    end else if (step_i) begin
      for (int n = 0; n < MaxTimers; n++) begin
        cnt_q[n] <= nxt_o.count[n];
        val_q[n] <= nxt_o.value[n];
      end
    end
  end

endmodule

@@ rtl/display_and_timer_event_scheduler.sv @@
// Top level of the display line timing and cascade timer scheduler.
// Depends on dtes_pkg, dtes_display and dtes_timers.
//
//  channel  | handshake               | word
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid_i / in_ready_o | elapsed_cycles_i
//  out      | out_valid_o/out_ready_i | irq, line, status, pulses, timers, next
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i stays high; an input word
// passes the input register, then the single compute pass (one display step
// plus the four-timer chain) into the result register; its result is offered.
// Reset restores timing state, config and valid flags, but not the data registers.
// A stalled result holds the result register; the input register still takes
// a word whenever the result register drains in the same cycle.
// Config writes are always taken; cfg_ready_o is tied high.
module display_and_timer_event_scheduler import dtes_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ElW-1:0]   elapsed_cycles_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       irq_flags_o,
  output logic [7:0]       cur_line_o,
  output logic [2:0]       status_flags_o,
  output logic             hblank_visible_pulse_o,
  output logic             vblank_start_pulse_o,
  output logic             frame_end_pulse_o,
  output logic [3:0]       timer_overflows_o,
  output logic [9:0]       next_event_cycles_o,
  output logic [15:0]      timer0_value_o,
  output logic [15:0]      timer1_value_o,
  output logic [15:0]      timer2_value_o,
  output logic [15:0]      timer3_value_o,
  // register writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i
);

  // Input register
  logic            in_valid_q;
  logic [ElW-1:0]  el_q;

  // Result register
  logic            out_valid_q;
  logic [6:0]      irq_q;
  logic [7:0]      line_q;
  logic [2:0]      status_q;
  logic            hpulse_q, vpulse_q, fpulse_q;
  logic [3:0]      ovf_q;
  logic [9:0]      next_q;
  logic [MaxTimers-1:0][15:0] value_q;

  logic            fire;
  cfg_wr_t         cfg;
  disp_out_t       disp;
  timer_out_t      tmr;
  tcount_t         nxt_min;
  logic [9:0]      next_d;

  // Compute pass runs when an input word waits and the result slot frees up
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  assign cfg.en   = cfg_valid_i;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_data_i;

  dtes_display u_display (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (fire),
    .el_i   (el_q),
    .nxt_o  (disp)
  );

  dtes_timers u_timers (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (fire),
    .el_i   (el_q),
    .nxt_o  (tmr)
  );

  // Cycles to next event: least of display countdown and prescale counts,
  // clamped into 0..one draw phase
  always_comb begin
    nxt_min = {{(CntW-DispW){disp.countdown[DispW-1]}}, disp.countdown};
    for (int n = 0; n < MaxTimers; n++) begin
      if (tmr.prescale[n] && $signed(tmr.count[n]) < nxt_min) nxt_min = tmr.count[n];
    end
    if (nxt_min < 0)               next_d = '0;
    else if (nxt_min > DrawCycles) next_d = 10'(DrawCycles);
    else                           next_d = nxt_min[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) el_q <= elapsed_cycles_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      irq_q    <= {tmr.irq, disp.irq};
      line_q   <= disp.line;
      status_q <= disp.flags;
      hpulse_q <= disp.hpulse;
      vpulse_q <= disp.vpulse;
      fpulse_q <= disp.fpulse;
      ovf_q    <= tmr.ovf;
      next_q   <= next_d;
      value_q  <= tmr.value;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign irq_flags_o            = irq_q;
  assign cur_line_o             = line_q;
  assign status_flags_o         = status_q;
  assign hblank_visible_pulse_o = hpulse_q;
  assign vblank_start_pulse_o   = vpulse_q;
  assign frame_end_pulse_o      = fpulse_q;
  assign timer_overflows_o      = ovf_q;
  assign next_event_cycles_o    = next_q;
  assign timer0_value_o         = value_q[0];
  assign timer1_value_o         = value_q[1];
  assign timer2_value_o         = value_q[2];
  assign timer3_value_o         = value_q[3];

  // A compute pass always leaves a result behind
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("result lost after compute pass");

  // Line counter stays within the frame
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> line_q < 8'(FrameLines)) else $error("line out of range");

  // Frame end leaves the counter at line zero, out of vblank
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fpulse_q |-> line_q == '0 && !status_q[0])
    else $error("bad wrap at frame end");

  // Vblank start only on line 160 with the vblank flag set
  a_vblank_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vpulse_q |-> line_q == 8'(VblankLine) && status_q[0])
    else $error("bad vblank start");

  // Next event never exceeds one draw phase
  a_next_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> next_q <= 10'(DrawCycles)) else $error("next event out of range");

endmodule
